### sv/lrpo_pkg.sv
// shared types, constants and helper functions of the linf / ridge proximal unit
package lrpo_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int IW2_BITS    = 52;
    localparam int T_SHIFT     = IW2_BITS - 2 * FRAC_BITS;
    localparam int MAX_LEN_DEF = 64;
    localparam int IDX_MAX_W   = 10;
    localparam int CNT_MAX_W   = 11;
    localparam int FIFO_DEPTH  = 2;
    localparam int DIV_NW      = 82;
    localparam int DIV_DW      = 64;
    localparam int CFG_IDX_W   = 4;
    localparam int OUT_IDX_W   = 6;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = CFG_IDX_W'(1);

    localparam logic [31:0] LAMBDA_RST = 32'd65536;
    localparam logic [62:0] SUM_CAP    = 63'd1 << 62;
    localparam logic [62:0] T_CAP      = 63'd1 << 62;
    localparam logic [62:0] TJ_LIM     = (63'd1 << 48) - 63'd1;
    localparam logic [32:0] M_CAP      = 33'd1 << 32;

    typedef enum logic [2:0] {
        CMD_HOLD  = 3'b001,
        CMD_RIDGE = 3'b010,
        CMD_VEC   = 3'b100
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind              kind;
        logic                   store_en;
        logic                   last;
        logic [IDX_MAX_W-1:0]   pos;
        logic [CNT_MAX_W-1:0]   count;
        logic [31:0]            x;
        logic [31:0]            w;
    } t_cmd;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [31:0] apply_sign(input logic neg, input logic [31:0] m);
        apply_sign = neg ? (32'd0 - m) : m;
    endfunction

endpackage

### sv/lrpo_ifs.sv
// stream and configuration interfaces of the linf / ridge proximal unit
interface lrpo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_value;
    logic [31:0]        weight;
    logic               last;
    modport source (output valid, x_value, weight, last, input ready);
    modport sink   (input valid, x_value, weight, last, output ready);
endinterface

interface lrpo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] prox_value;
    logic [5:0]         element_index;
    logic               last_out;
    modport source (output valid, prox_value, element_index, last_out, input ready);
    modport sink   (input valid, prox_value, element_index, last_out, output ready);
endinterface

interface lrpo_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/lrpo_div.sv
// restoring divider, one quotient bit per cycle
module lrpo_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lrpo_pkg::DIV_NW-1:0] i_num,
    input  logic [lrpo_pkg::DIV_DW-1:0] i_den,
    output logic                        o_done,
    output logic [lrpo_pkg::DIV_NW-1:0] o_quot
);
    import lrpo_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_nq;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   w_sh;
    logic              w_ge;
    logic [DIV_DW:0]   w_diff;

    assign w_sh   = {r_rem, r_nq[DIV_NW-1]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(DIV_NW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_nq   <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_nq  <= {r_nq[DIV_NW-2:0], w_ge};
                r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_sh[DIV_DW-1:0];
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_nq;

endmodule

### sv/lrpo_fifo.sv
// short command queue between front and back
module lrpo_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lrpo_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output lrpo_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import lrpo_pkg::*;

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    t_cmd        r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic [AW-1:0] n_wp;
    logic [AW-1:0] n_rp;

    assign o_full  = r_cnt == (AW+1)'(FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_wp = (r_wp == AW'(FIFO_DEPTH - 1)) ? '0 : r_wp + AW'(1);
        n_rp = (r_rp == AW'(FIFO_DEPTH - 1)) ? '0 : r_rp + AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

endmodule

### sv/lrpo_front.sv
// input side: accepts items, counts elements and classifies them into commands
module lrpo_front #(
    parameter int MAX_LEN = lrpo_pkg::MAX_LEN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lrpo_in_if.sink        i_in,
    input  logic           i_mode,
    input  logic           i_full,
    output logic           o_push,
    output lrpo_pkg::t_cmd o_cmd
);
    import lrpo_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          w_room;
    logic          w_acc;
    logic [CW-1:0] w_pos;
    logic [CW-1:0] w_after;
    logic [31:0]   w_wcl;

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && !i_full;
    assign w_room     = r_cnt < CW'(MAX_LEN);
    assign w_pos      = w_room ? r_cnt : CW'(MAX_LEN - 1);
    assign w_after    = w_room ? r_cnt + CW'(1) : r_cnt;
    assign w_wcl      = (i_in.weight == 32'd0) ? 32'd1 : i_in.weight;

    always_comb begin
        o_cmd.store_en = w_room;
        o_cmd.last     = i_in.last;
        o_cmd.pos      = IDX_MAX_W'(w_pos);
        o_cmd.count    = CNT_MAX_W'(w_after);
        o_cmd.x        = i_in.x_value;
        o_cmd.w        = w_wcl;
        if (i_mode) begin
            o_cmd.kind = CMD_RIDGE;
        end else if (i_in.last) begin
            o_cmd.kind = CMD_VEC;
        end else begin
            o_cmd.kind = CMD_HOLD;
        end
        n_cnt = i_in.last ? '0 : w_after;
    end

    assign o_push = w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_acc) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

### sv/lrpo_back.sv
// execution side: element stores, ridge division, linf threshold search and output pass
module lrpo_back #(
    parameter int MAX_LEN = lrpo_pkg::MAX_LEN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  lrpo_pkg::t_cmd i_cmd,
    output logic           o_pop,
    input  logic [31:0]    i_lambda,
    lrpo_out_if.source     o_out
);
    import lrpo_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'b0000_0000_0000_0001,
        ST_RMUL  = 16'b0000_0000_0000_0010,
        ST_RDIV  = 16'b0000_0000_0000_0100,
        ST_EMIT  = 16'b0000_0000_0000_1000,
        ST_PRD   = 16'b0000_0000_0001_0000,
        ST_PMUL  = 16'b0000_0000_0010_0000,
        ST_PZDIV = 16'b0000_0000_0100_0000,
        ST_PVDIV = 16'b0000_0000_1000_0000,
        ST_PCHK  = 16'b0000_0001_0000_0000,
        ST_SRCH  = 16'b0000_0010_0000_0000,
        ST_AREQ  = 16'b0000_0100_0000_0000,
        ST_ACC   = 16'b0000_1000_0000_0000,
        ST_TDIV  = 16'b0001_0000_0000_0000,
        ST_NCHK  = 16'b0010_0000_0000_0000,
        ST_ORD   = 16'b0100_0000_0000_0000,
        ST_OCALC = 16'b1000_0000_0000_0000
    } t_state;

    t_state          r_st;
    logic            r_odiv;
    logic [CW-1:0]   r_n;
    logic [CW-1:0]   r_i;
    logic [CW-1:0]   r_j;
    logic [31:0]     r_ax;
    logic            r_neg;
    logic [31:0]     r_w;
    logic [5:0]      r_pos;
    logic            r_last;
    logic            r_ridge;
    logic [63:0]     r_prod;
    logic [63:0]     r_ww;
    logic [47:0]     r_z;
    logic [62:0]     r_s;
    logic [62:0]     r_c;
    logic [63:0]     r_vs;
    logic [62:0]     r_tj;
    logic [62:0]     r_t;
    logic            r_zero;
    logic [MAX_LEN-1:0] r_taken;
    logic [CW-1:0]   r_scnt;
    logic            r_svld;
    logic [IW-1:0]   r_sidx;
    logic            r_found;
    logic [63:0]     r_best;
    logic [IW-1:0]   r_k;
    logic            r_pend;
    logic            r_dreq;
    logic            n_dreq;
    logic [31:0]     r_y;
    logic            r_ov;
    logic [31:0]     r_op;
    logic [5:0]      r_oi;
    logic            r_ol;

    logic [31:0]     m_val [MAX_LEN];
    logic [31:0]     m_wt  [MAX_LEN];
    logic [47:0]     m_z   [MAX_LEN];
    logic [63:0]     m_b   [MAX_LEN];
    logic [52:0]     m_v   [MAX_LEN];
    logic [31:0]     r_rd_val;
    logic [31:0]     r_rd_wt;
    logic [47:0]     r_rd_z;
    logic [63:0]     r_rd_b;
    logic [52:0]     r_rd_v;

    logic [IW-1:0]     w_ra;
    logic              w_we;
    logic              w_vwe;
    logic [DIV_NW-1:0] w_dnum;
    logic [DIV_DW-1:0] w_dden;
    logic              w_ddone;
    logic [DIV_NW-1:0] w_dq;
    logic              w_oload;
    logic              w_sissue;
    logic              w_better;
    logic              w_ilast;
    logic [63:0]       w_ssum;
    logic [63:0]       w_csum;
    logic [62:0]       w_cnew;
    logic [62:0]       w_tjn;
    logic [31:0]       w_ym;
    logic [31:0]       w_rax;

    assign o_pop    = (r_st == ST_IDLE) && !i_empty;
    assign w_we     = o_pop && i_cmd.store_en;
    assign w_vwe    = (r_st == ST_PVDIV) && w_ddone;
    assign w_oload  = (r_st == ST_EMIT) && (!r_ov || o_out.ready);
    assign w_sissue = r_scnt < r_n;
    assign w_better = r_svld && !r_taken[r_sidx] && (!r_found || r_rd_b > r_best);
    assign w_ilast  = (r_i + CW'(1)) == r_n;
    assign w_ssum   = 64'(r_s) + 64'(r_z);
    assign w_csum   = 64'(r_c) + 64'(r_rd_z);
    assign w_cnew   = (w_csum > 64'(SUM_CAP)) ? SUM_CAP : w_csum[62:0];
    assign w_tjn    = (w_dq > DIV_NW'(T_CAP)) ? T_CAP : w_dq[62:0];
    assign w_rax    = mag32(r_rd_val);

    assign n_dreq = (r_st == ST_RMUL) || (r_st == ST_PMUL)
                 || ((r_st == ST_PZDIV) && w_ddone)
                 || ((r_st == ST_ACC) && (w_cnew > 63'(i_lambda)))
                 || ((r_st == ST_OCALC) && !r_odiv && !r_zero);

    always_comb begin
        if (w_dq > DIV_NW'(M_CAP)) begin
            w_ym = r_ax;
        end else begin
            w_ym = (w_dq[32:0] < 33'(r_ax)) ? w_dq[31:0] : r_ax;
        end
    end

    always_comb begin
        case (r_st)
            ST_SRCH: w_ra = r_scnt[IW-1:0];
            ST_AREQ: w_ra = r_k;
            default: w_ra = r_i[IW-1:0];
        endcase
    end

    always_comb begin
        case (r_st)
            ST_RDIV: begin
                w_dnum = DIV_NW'({r_ax, {FRAC_BITS{1'b0}}});
                w_dden = (DIV_DW'(1) << FRAC_BITS) + (r_prod >> (FRAC_BITS - 1));
            end
            ST_PZDIV: begin
                w_dnum = DIV_NW'({r_ax, {FRAC_BITS{1'b0}}});
                w_dden = DIV_DW'(r_w);
            end
            ST_PVDIV: begin
                w_dnum = DIV_NW'(1) << IW2_BITS;
                w_dden = r_ww;
            end
            ST_TDIV: begin
                w_dnum = DIV_NW'(r_c - 63'(i_lambda)) << T_SHIFT;
                w_dden = r_vs;
            end
            ST_OCALC: begin
                w_dnum = DIV_NW'(r_t) << FRAC_BITS;
                w_dden = DIV_DW'(r_w);
            end
            default: begin
                w_dnum = '0;
                w_dden = '0;
            end
        endcase
    end

    lrpo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dreq),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_ddone),
        .o_quot  (w_dq)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            m_val[i_cmd.pos[IW-1:0]] <= i_cmd.x;
            m_wt[i_cmd.pos[IW-1:0]]  <= i_cmd.w;
        end
        if (w_vwe) begin
            m_z[r_i[IW-1:0]] <= r_z;
            m_b[r_i[IW-1:0]] <= r_prod;
            m_v[r_i[IW-1:0]] <= w_dq[52:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_val <= m_val[w_ra];
        r_rd_wt  <= m_wt[w_ra];
        r_rd_z   <= m_z[w_ra];
        r_rd_b   <= m_b[w_ra];
        r_rd_v   <= m_v[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_dreq  <= 1'b0;
            r_odiv  <= 1'b0;
            r_ov    <= 1'b0;
            r_taken <= '0;
            r_svld  <= 1'b0;
        end else begin
            r_dreq <= n_dreq;
            if (w_oload) begin
                r_ov <= 1'b1;
                r_op <= apply_sign(r_neg, r_y);
                r_oi <= r_ridge ? r_pos : OUT_IDX_W'(r_i);
                r_ol <= r_ridge ? r_last : w_ilast;
            end else if (o_out.valid && o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (o_pop) begin
                        case (i_cmd.kind)
                            CMD_RIDGE: begin
                                r_ax    <= mag32(i_cmd.x);
                                r_neg   <= i_cmd.x[31];
                                r_w     <= i_cmd.w;
                                r_pos   <= i_cmd.pos[OUT_IDX_W-1:0];
                                r_last  <= i_cmd.last;
                                r_ridge <= 1'b1;
                                r_st    <= ST_RMUL;
                            end
                            CMD_VEC: begin
                                r_n     <= CW'(i_cmd.count);
                                r_i     <= '0;
                                r_s     <= '0;
                                r_ridge <= 1'b0;
                                r_st    <= ST_PRD;
                            end
                            default: r_st <= ST_IDLE;
                        endcase
                    end
                end
                ST_RMUL: begin
                    r_prod <= 64'(i_lambda) * 64'(r_w);
                    r_st   <= ST_RDIV;
                end
                ST_RDIV: begin
                    if (w_ddone) begin
                        r_y  <= w_dq[31:0];
                        r_st <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_oload) begin
                        if (r_ridge || w_ilast) begin
                            r_st <= ST_IDLE;
                        end else begin
                            r_i  <= r_i + CW'(1);
                            r_st <= ST_ORD;
                        end
                    end
                end
                ST_PRD: begin
                    r_st <= ST_PMUL;
                end
                ST_PMUL: begin
                    r_ax   <= w_rax;
                    r_w    <= r_rd_wt;
                    r_ww   <= 64'(r_rd_wt) * 64'(r_rd_wt);
                    r_st   <= ST_PZDIV;
                end
                ST_PZDIV: begin
                    r_prod <= 64'(r_ax) * 64'(r_w);
                    if (w_ddone) begin
                        r_z    <= w_dq[47:0];
                        r_st   <= ST_PVDIV;
                    end
                end
                ST_PVDIV: begin
                    if (w_ddone) begin
                        r_s <= (w_ssum > 64'(SUM_CAP)) ? SUM_CAP : w_ssum[62:0];
                        if (w_ilast) begin
                            r_st <= ST_PCHK;
                        end else begin
                            r_i  <= r_i + CW'(1);
                            r_st <= ST_PRD;
                        end
                    end
                end
                ST_PCHK: begin
                    r_t <= '0;
                    if (r_s > 63'(i_lambda)) begin
                        r_zero  <= 1'b0;
                        r_taken <= '0;
                        r_c     <= '0;
                        r_vs    <= '0;
                        r_j     <= '0;
                        r_pend  <= 1'b0;
                        r_scnt  <= '0;
                        r_svld  <= 1'b0;
                        r_found <= 1'b0;
                        r_st    <= ST_SRCH;
                    end else begin
                        r_zero <= 1'b1;
                        r_i    <= '0;
                        r_st   <= ST_ORD;
                    end
                end
                ST_SRCH: begin
                    r_svld <= w_sissue;
                    r_sidx <= r_scnt[IW-1:0];
                    if (w_sissue) begin
                        r_scnt <= r_scnt + CW'(1);
                    end
                    if (w_better) begin
                        r_found <= 1'b1;
                        r_best  <= r_rd_b;
                        r_k     <= r_sidx;
                    end
                    if (!w_sissue && !r_svld) begin
                        r_st <= r_pend ? ST_NCHK : ST_AREQ;
                    end
                end
                ST_AREQ: begin
                    r_taken[r_k] <= 1'b1;
                    r_st         <= ST_ACC;
                end
                ST_ACC: begin
                    r_c  <= w_cnew;
                    r_vs <= r_vs + 64'(r_rd_v);
                    if (w_cnew > 63'(i_lambda)) begin
                        r_st   <= ST_TDIV;
                    end else if ((r_j + CW'(1)) == r_n) begin
                        r_i  <= '0;
                        r_st <= ST_ORD;
                    end else begin
                        r_j     <= r_j + CW'(1);
                        r_pend  <= 1'b0;
                        r_scnt  <= '0;
                        r_found <= 1'b0;
                        r_st    <= ST_SRCH;
                    end
                end
                ST_TDIV: begin
                    if (w_ddone) begin
                        r_tj <= w_tjn;
                        if ((r_j + CW'(1)) == r_n) begin
                            r_t  <= w_tjn;
                            r_i  <= '0;
                            r_st <= ST_ORD;
                        end else begin
                            r_j     <= r_j + CW'(1);
                            r_pend  <= 1'b1;
                            r_scnt  <= '0;
                            r_found <= 1'b0;
                            r_st    <= ST_SRCH;
                        end
                    end
                end
                ST_NCHK: begin
                    r_pend <= 1'b0;
                    if ((r_tj > TJ_LIM) || (r_best <= (64'(r_tj) << FRAC_BITS))) begin
                        r_t  <= r_tj;
                        r_i  <= '0;
                        r_st <= ST_ORD;
                    end else begin
                        r_st <= ST_AREQ;
                    end
                end
                ST_ORD: begin
                    r_odiv <= 1'b0;
                    r_st   <= ST_OCALC;
                end
                ST_OCALC: begin
                    if (!r_odiv) begin
                        r_ax  <= w_rax;
                        r_neg <= r_rd_val[31];
                        r_w   <= r_rd_wt;
                        if (r_zero) begin
                            r_y  <= '0;
                            r_st <= ST_EMIT;
                        end else begin
                            r_odiv <= 1'b1;
                        end
                    end else if (w_ddone) begin
                        r_y  <= w_ym;
                        r_st <= ST_EMIT;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.prox_value    = r_op;
    assign o_out.element_index = r_oi;
    assign o_out.last_out      = r_ol;

endmodule

### sv/linf_ridge_proximal_operator_unit.sv
// ridge item: its result is computed by the 82-step serial divider
// linf vector of n elements: elements are taken one per cycle while the command queue has room,
//   then per-element quotients, up to n search passes, up to n threshold quotients
//   and the output pass, all sharing one serial divider
// the queue holds up to two commands of the next vector while the current one is worked off
// synchronous active-low reset clears control state and config; element stores are not cleared
module linf_ridge_proximal_operator_unit #(
    parameter int MAX_LEN = lrpo_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lrpo_in_if.sink    i_in,
    lrpo_out_if.source o_out,
    lrpo_cfg_if.sink   i_cfg
);
    import lrpo_pkg::*;

    logic        r_mode;
    logic [31:0] r_lambda;
    logic        w_push;
    logic        w_pop;
    logic        w_full;
    logic        w_empty;
    t_cmd        w_cmd_in;
    t_cmd        w_cmd_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_lambda <= LAMBDA_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MODE:   r_mode   <= i_cfg.data[0];
                REG_LAMBDA: r_lambda <= i_cfg.data;
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    lrpo_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_mode  (r_mode),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in)
    );

    lrpo_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_empty)
    );

    lrpo_back #(.MAX_LEN(MAX_LEN)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_cmd    (w_cmd_out),
        .o_pop    (w_pop),
        .i_lambda (r_lambda),
        .o_out    (o_out)
    );

endmodule

### sv/lrpo_check.sv
// port-level checks of the linf / ridge proximal unit, bound to the top level
module lrpo_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value,
    input logic [5:0]  i_out_index,
    input logic        i_out_last,
    input logic        i_cfg_ready
);

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
            && $stable(i_out_index) && $stable(i_out_last))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_cfg_ready)
        else $error("config port not ready");

endmodule

bind linf_ridge_proximal_operator_unit lrpo_check u_lrpo_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.prox_value),
    .i_out_index (o_out.element_index),
    .i_out_last  (o_out.last_out),
    .i_cfg_ready (i_cfg.ready)
);

### test/lrpo_checker.sv
`timescale 1ns / 100ps
// item monitor, proximal result predictor and result comparator for the proximal unit
module lrpo_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lrpo_in_if   in_ch,
    lrpo_out_if  out_ch,
    lrpo_cfg_if  cfg_ch,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);
    import lrpo_pkg::*;

    localparam int LEN = 64;

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  index;
        logic        last;
    } t_prox;

    t_prox       prox_q[$];
    logic        mode;
    logic [31:0] lam;
    logic [31:0] x_mem[LEN];
    logic [31:0] w_mem[LEN];
    int          held;

    function automatic logic [63:0] abs_of(input logic [31:0] v);
        return v[31] ? {32'd0, 32'd0 - v} : {32'd0, v};
    endfunction

    function automatic logic [31:0] signed_of(input logic [31:0] v, input logic [63:0] y);
        return v[31] ? 32'd0 - y[31:0] : y[31:0];
    endfunction

    // min(floor(num * 2^sh / den), cap), bit serial as the block does it
    function automatic logic [63:0] scaled_quot(input logic [63:0] num, input int sh,
                                                input logic [63:0] den, input logic [63:0] cap);
        logic [63:0] q, r;
        if (den == 0) return cap;
        q = num / den;
        r = num % den;
        if (q > cap) return cap;
        for (int i = 0; i < sh; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= den) begin
                r = r - den;
                q = q + 1;
            end
            if (q > cap) return cap;
        end
        return q;
    endfunction

    function automatic void solve_linf();
        logic [63:0] z[LEN], b[LEN], v[LEN];
        logic [63:0] s, c, vs, t, tj, ax, ww, m, y;
        int          ord[LEN];
        int          j, k;
        logic        stop;
        t_prox       p;
        s = 0; c = 0; vs = 0; t = 0;
        for (int i = 0; i < held; i++) begin
            ax = abs_of(x_mem[i]);
            ww = {32'd0, w_mem[i]};
            z[i] = (ax << FRAC_BITS) / ww;
            b[i] = ax * ww;
            v[i] = (64'd1 << IW2_BITS) / (ww * ww);
            s = s + z[i];
            if (s > (64'd1 << 62)) s = 64'd1 << 62;
        end
        if (s > lam) begin
            for (int i = 0; i < held; i++) begin
                j = i;
                while (j > 0 && b[ord[j-1]] < b[i]) begin
                    ord[j] = ord[j-1];
                    j--;
                end
                ord[j] = i;
            end
            for (j = 0; j < held; j++) begin
                k = ord[j];
                c = c + z[k];
                if (c > (64'd1 << 62)) c = 64'd1 << 62;
                vs = vs + v[k];
                if (c > lam) begin
                    tj = scaled_quot(c - lam, T_SHIFT, vs, 64'd1 << 62);
                    stop = (j == held - 1);
                    if (!stop && (tj > (64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS)
                                  || b[ord[j+1]] <= (tj << FRAC_BITS)))
                        stop = 1'b1;
                    if (stop) begin
                        t = tj;
                        break;
                    end
                end
            end
        end
        for (int i = 0; i < held; i++) begin
            y = 0;
            if (s > lam) begin
                ax = abs_of(x_mem[i]);
                m = scaled_quot(t, FRAC_BITS, {32'd0, w_mem[i]}, 64'd1 << 32);
                y = (m < ax) ? m : ax;
            end
            p.value = signed_of(x_mem[i], y);
            p.index = i[5:0];
            p.last  = (i == held - 1);
            prox_q.push_back(p);
        end
        held = 0;
    endfunction

    function automatic void take_item(input logic [31:0] x, input logic [31:0] w_in,
                                      input logic l);
        logic [31:0] w;
        int          pos;
        logic [63:0] d;
        t_prox       p;
        w = (w_in == 0) ? 32'd1 : w_in;
        if (held < LEN) begin
            x_mem[held] = x;
            w_mem[held] = w;
            pos = held;
            held++;
        end else begin
            pos = LEN - 1;
        end
        if (mode) begin
            d = (64'd1 << FRAC_BITS) + (({32'd0, lam} * {32'd0, w}) >> (FRAC_BITS - 1));
            p.value = signed_of(x, (abs_of(x) << FRAC_BITS) / d);
            p.index = pos[5:0];
            p.last  = l;
            prox_q.push_back(p);
            if (l) held = 0;
        end else if (l) begin
            solve_linf();
        end
    endfunction

    always @(posedge i_clk) begin
        t_prox got, want;
        if (!i_rst_n) begin
            mode = 1'b0;
            lam  = LAMBDA_RST;
            held = 0;
            prox_q.delete();
            o_errors  = 0;
            o_checked = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == REG_MODE) mode = cfg_ch.data[0];
                else if (cfg_ch.index == REG_LAMBDA) lam = cfg_ch.data;
            end
            if (in_ch.valid && in_ch.ready)
                take_item(in_ch.x_value, in_ch.weight, in_ch.last);
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.prox_value, out_ch.element_index, out_ch.last_out};
                if (prox_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result: value %h index %0d last %0d",
                                 got.value, got.index, got.last);
                end else begin
                    want = prox_q.pop_front();
                    o_checked++;
                    if (got !== want) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                                     want.value, want.index, want.last,
                                     got.value, got.index, got.last);
                    end
                end
            end
        end
        o_pending = prox_q.size();
    end
endmodule

### test/tb.sv
`timescale 1ns / 100ps
// top of the proximal unit testbench: clock, reset, stimulus, handshake pressure and verdict
module tb;
    import lrpo_pkg::*;

    localparam int  N_ITEMS = 430;
    localparam int  HOLD    = 300;
    localparam longint LIMIT = 3000000;

    logic   i_clk;
    logic   i_rst_n;
    int     idle_pct;
    int     stall_pct;
    int     n_sent;
    int     n_base;
    longint cycles;
    int     errors, pending, checked;

    lrpo_in_if  in_ch();
    lrpo_out_if out_ch();
    lrpo_cfg_if cfg_ch();

    linf_ridge_proximal_operator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    lrpo_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_ch    (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send(input logic [31:0] x, input logic [31:0] w, input logic l);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.x_value <= x;
        in_ch.weight  <= w;
        in_ch.last    <= l;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (HOLD) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [3:0] idx, input logic [31:0] data);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_cfg(input logic m, input logic [31:0] l);
        cfg_write(REG_MODE, {31'd0, m});
        cfg_write(REG_LAMBDA, l);
    endtask

    function automatic logic [31:0] rand_x();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 1 << 20)) * ($urandom_range(1) ? 1 : -1);
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'($urandom_range(0, 1 << 24)) - 32'd1 << 23;
        endcase
    endfunction

    function automatic logic [31:0] rand_w();
        case ($urandom_range(7))
            0: return 32'd0;
            1, 2: return $urandom;
            3: return $urandom_range(1, 255);
            default: return 32'($urandom_range(1 << 12, 1 << 20));
        endcase
    endfunction

    function automatic logic [31:0] rand_lambda();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd65536;
            3: return $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_vec(input int n);
        for (int i = 0; i < n; i++) send(rand_x(), rand_w(), i == n - 1);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.x_value = '0;
        in_ch.weight  = '0;
        in_ch.last    = 1'b0;
        out_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        n_sent        = 0;
        n_base        = 0;
        cycles        = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // linf at reset lambda: single element, ties, extremes, zero weight
        send(32'h0005_0000, 32'h0001_0000, 1'b1);
        send(32'h0002_0000, 32'h0001_0000, 1'b0);
        send(32'hFFFE_0000, 32'h0001_0000, 1'b0);
        send(32'h0002_0000, 32'h0001_0000, 1'b1);
        send(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send(32'h7FFF_FFFF, 32'd0, 1'b1);
        // all weights so large that the inverse square sum is zero
        set_cfg(1'b0, 32'd0);
        send(32'd1, 32'h7FFF_FFFF, 1'b0);
        send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // dual norm below lambda gives zeros
        set_cfg(1'b0, 32'hFFFF_FFFF);
        send(32'h0000_0100, 32'h0001_0000, 1'b0);
        send(32'hFFFF_FF00, 32'h0001_0000, 1'b1);
        // ridge extremes
        set_cfg(1'b1, 32'd0);
        send(32'h7FFF_FFFF, 32'd1, 1'b0);
        send(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send(32'd0, 32'd0, 1'b1);
        set_cfg(1'b1, 32'hFFFF_FFFF);
        send(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send(32'h7FFF_FFFF, 32'd0, 1'b1);
        // mode switch inside a vector, both ways
        set_cfg(1'b0, 32'd65536);
        send(32'h0003_0000, 32'h0001_0000, 1'b0);
        send(32'hFFFD_0000, 32'h0002_0000, 1'b0);
        cfg_write(REG_MODE, 32'd1);
        send(32'h0001_0000, 32'h0001_0000, 1'b0);
        cfg_write(REG_MODE, 32'd0);
        send(32'h0004_0000, 32'h0000_8000, 1'b1);
        // store overflow in both modes
        set_cfg(1'b1, 32'd65536);
        for (int i = 0; i < 66; i++) send(rand_x(), rand_w(), i == 65);
        set_cfg(1'b0, 32'd4096);
        for (int i = 0; i < 66; i++) send(rand_x(), rand_w(), i == 65);

        n_base = n_sent;
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 71 : 34) : 0;
            stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 71 : 34) : 0;
            while (n_sent < n_base + (N_ITEMS - n_base) * (phase + 1) / 4) begin
                set_cfg($urandom_range(1), rand_lambda());
                repeat ($urandom_range(1, 4))
                    send_vec(($urandom_range(9) == 0) ? $urandom_range(9, 20)
                                                      : $urandom_range(1, 8));
            end
        end
        drain();

        $display("sent %0d items and checked %0d results in ridge and linf modes,",
                 n_sent, checked);
        $display("including store overflow, mode switches and four handshake pressure mixes");
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
